### hw/rtl/sdgr_pkg.sv
// Shared types, constants and the glyph table for the scaled digit glyph renderer.
// No dependencies; every other file imports this package.
package sdgr_pkg;

  localparam int COORD_BITS    = 12;
  localparam int GLYPH_ROWS    = 5;
  localparam int GLYPH_COLS    = 3;
  localparam int GLYPH_CELLS   = GLYPH_ROWS * GLYPH_COLS;
  localparam int CELL_SCALE    = 3;
  localparam int GLYPH_COUNT   = 11;
  localparam int GLYPH_IDX_BITS = $clog2(GLYPH_COUNT);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COORD_BITS-1:0] GLYPH_ADVANCE = COORD_BITS'(15);
  localparam logic [COORD_BITS-1:0] SPACE_ADVANCE = COORD_BITS'(10);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [GLYPH_IDX_BITS-1:0] SLASH_GLYPH = GLYPH_IDX_BITS'(10);

  localparam logic [31:0] DRAW_COLOR_RESET = 32'h00FF_FFFF;

  // Rows top to bottom, leftmost column in the most significant bit of each row
  localparam logic [GLYPH_CELLS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    15'b111_101_101_101_111,
    15'b010_110_010_010_111,
    15'b111_001_111_100_111,
    15'b111_001_111_001_111,
    15'b101_101_111_001_001,
    15'b111_100_111_001_111,
    15'b111_100_111_101_111,
    15'b111_001_001_001_001,
    15'b111_101_111_101_111,
    15'b111_101_111_001_001,
    15'b001_010_100_010_001
  };

  typedef struct packed {
    logic                  start_of_string;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [7:0]            char_code;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] block_x;
    logic [COORD_BITS-1:0] block_y;
    logic [31:0]           block_color;
    logic                  last_block;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  pen_x;
    logic [COORD_BITS-1:0]  pen_y;
    logic [GLYPH_CELLS-1:0] cells;
  } glyph_job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

### hw/rtl/sdgr_front.sv
// Front end: accepts character words, tracks the pen and queues glyph jobs.
// Depends on sdgr_pkg.
module sdgr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdgr_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output sdgr_pkg::glyph_job_t q_job
);
  import sdgr_pkg::*;

  logic [COORD_BITS-1:0]     pen_x;
  logic [COORD_BITS-1:0]     pen_y;
  logic [COORD_BITS-1:0]     pen_x_next;
  logic [COORD_BITS-1:0]     base_x;
  logic [COORD_BITS-1:0]     base_y;
  logic                      accept;
  logic                      is_digit;
  logic                      is_glyph;
  logic [GLYPH_IDX_BITS-1:0] glyph_idx;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign base_x = in_data.start_of_string ? in_data.start_x : pen_x;
  assign base_y = in_data.start_of_string ? in_data.start_y : pen_y;

  always_comb begin
    logic [7:0] offset;
    offset    = in_data.char_code - CHAR_ZERO;
    is_digit  = in_data.char_code inside {[CHAR_ZERO:CHAR_NINE]};
    is_glyph  = is_digit || (in_data.char_code == CHAR_SLASH);
    glyph_idx = is_digit ? offset[GLYPH_IDX_BITS-1:0] : SLASH_GLYPH;
  end

  always_comb begin
    if (is_glyph) begin
      pen_x_next = base_x + GLYPH_ADVANCE;
    end else if (in_data.char_code == CHAR_SPACE) begin
      pen_x_next = base_x + SPACE_ADVANCE;
    end else begin
      pen_x_next = base_x;
    end
  end

  assign q_push      = accept && is_glyph;
  assign q_job.pen_x = base_x;
  assign q_job.pen_y = base_y;
  assign q_job.cells = GLYPH_ROM[glyph_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (accept) begin
      pen_x <= pen_x_next;
      pen_y <= base_y;
    end
  end

endmodule

### hw/rtl/sdgr_queue.sv
// Short job queue between front and back end, register based.
// Depends on sdgr_pkg.
module sdgr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sdgr_pkg::glyph_job_t   push_job,
  input  logic                   pop,
  output sdgr_pkg::glyph_job_t   head_job,
  output sdgr_pkg::queue_status_t status
);
  import sdgr_pkg::*;

  glyph_job_t           entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign status.valid = (count != '0);
  assign status.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/sdgr_back.sv
// Back end: walks the lit cells of one glyph job into an output register, one
// block word per cycle while the output is not stalled. Depends on sdgr_pkg.
module sdgr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            draw_color,
  input  logic                   q_valid,
  input  sdgr_pkg::glyph_job_t   q_job,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sdgr_pkg::out_item_t    out_data
);
  import sdgr_pkg::*;

  logic                   active;
  logic [COORD_BITS-1:0]  cur_x;
  logic [COORD_BITS-1:0]  cur_y;
  logic [GLYPH_CELLS-1:0] cells;
  logic [GLYPH_CELLS-1:0] cells_next;
  logic [GLYPH_CELLS-1:0] sel_bit;
  logic [COORD_BITS-1:0]  sel_dx;
  logic [COORD_BITS-1:0]  sel_dy;
  logic                   out_free;
  logic                   emit;
  logic                   emit_last;

  // Pick the first lit cell in row-major order
  always_comb begin
    logic found;
    found   = 1'b0;
    sel_bit = '0;
    sel_dx  = '0;
    sel_dy  = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        if (!found && cells[GLYPH_CELLS-1-(r*GLYPH_COLS+c)]) begin
          found = 1'b1;
          sel_bit[GLYPH_CELLS-1-(r*GLYPH_COLS+c)] = 1'b1;
          sel_dx = COORD_BITS'(c * CELL_SCALE);
          sel_dy = COORD_BITS'(r * CELL_SCALE);
        end
      end
    end
  end

  assign cells_next = cells & ~sel_bit;
  assign out_free   = !out_valid || !out_stall;
  assign emit       = active && out_free;
  assign emit_last  = emit && (cells_next == '0);
  assign q_pop      = q_valid && (!active || emit_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (emit_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_x <= q_job.pen_x;
      cur_y <= q_job.pen_y;
      cells <= q_job.cells;
    end else if (emit) begin
      cells <= cells_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.block_x     <= cur_x + sel_dx;
      out_data.block_y     <= cur_y + sel_dy;
      out_data.block_color <= draw_color;
      out_data.last_block  <= (cells_next == '0);
    end
  end

endmodule

### hw/rtl/scaled_digit_glyph_renderer.sv
// Top level of the scaled digit glyph renderer: colour register, front end,
// job queue and back end. Depends on sdgr_pkg, sdgr_front, sdgr_queue, sdgr_back.
//
// Input channel (in_valid/in_stall/in_data): one character word per cycle while
// in_stall is low; start_of_string loads the pen from start_x/start_y first.
// Digits and '/' draw a 3x5 glyph at three times scale, then move the pen 15
// to the right; a space moves it 10; any other byte leaves the pen alone.
// Output channel (out_valid/out_stall/out_data): one word per lit cell,
// row-major, giving the top-left corner of a 3x3 pixel block and the colour;
// last_block marks the final word of a character.
// An accepted glyph is pushed into the job queue, popped into the back end and
// then registered as block words at the output, one block word per cycle while
// out_stall is low. A glyph holds the back end for its lit-cell count (5 to 13)
// while the two-entry job queue lets the front end keep taking characters.
// in_stall rises only when the queue holds two waiting glyphs.
// Out stall holds the output register; the back end waits behind it.
// cfg_valid/cfg_ready/cfg_data writes draw_color; cfg_ready is always high.
// Reset clears the pen to 0,0, empties the queue and sets the colour to
// 0x00FFFFFF.
module scaled_digit_glyph_renderer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdgr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sdgr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import sdgr_pkg::*;

  logic [31:0]   draw_color;
  logic          q_push;
  logic          q_pop;
  glyph_job_t    push_job;
  glyph_job_t    head_job;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= DRAW_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      draw_color <= cfg_data;
    end
  end

  sdgr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_status.full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  sdgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  sdgr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .draw_color (draw_color),
    .q_valid    (q_status.valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Reset leaves nothing queued and nothing on the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !q_status.valid))
    else $error("output or queue not empty after reset");

  // The back end only takes a job that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.valid)
    else $error("job taken from empty queue");

  // A full queue stalls the front end, so nothing is pushed into it
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> (in_stall && !q_push))
    else $error("push into full queue");

  // A glyph entering an idle path is popped into the back end, then shows its first block
  a_first_block: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_status.valid && !out_valid && !q_pop) ##1 (q_pop && !out_valid)
    |=> ##1 out_valid)
    else $error("first block of glyph missing");

endmodule

### bench/tb_scaled_digit_glyph_renderer.sv
// Self-checking bench for the scaled digit glyph renderer: drives character words,
// predicts every pixel-block word and checks them in order as they leave the block.
// Depends on sdgr_pkg and the scaled_digit_glyph_renderer RTL.
module tb_scaled_digit_glyph_renderer;
  timeunit 1ns;
  timeprecision 1ps;
  import sdgr_pkg::*;

  localparam int RUN_LIMIT   = 1_000_000;
  localparam int SETTLE      = 24;
  localparam int PHASES      = 6;
  localparam int PHASE_CHARS = 55;
  localparam int DIR_ROWS    = 23;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    in_item_t              item;
    bit                    typed;
    int                    n_blocks;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [31:0] cfg_data = '0;

  // 3-bit font rows, top to bottom, leftmost column in the top bit
  logic [2:0] font [11][5] = '{
    '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
    '{3'h2, 3'h6, 3'h2, 3'h2, 3'h7},
    '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
    '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
    '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
    '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
    '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
    '{3'h7, 3'h1, 3'h1, 3'h1, 3'h1},
    '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
    '{3'h7, 3'h5, 3'h7, 3'h1, 3'h1},
    '{3'h1, 3'h2, 3'h4, 3'h2, 3'h1}
  };

  logic [COORD_BITS-1:0] pen_x = '0;
  logic [COORD_BITS-1:0] pen_y = '0;
  logic [31:0]           ink = DRAW_COLOR_RESET;
  out_item_t             pending_blocks [$];
  int                    mismatches = 0;
  int                    words_seen = 0;
  int                    cycles = 0;
  bit                    calm = 1'b0;
  int                    stall_left = 0;
  int                    hold_left = 0;
  bit                    held = 1'b0;

  scaled_digit_glyph_renderer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_item_t char_word(bit sos, int x, int y, logic [7:0] code);
    return '{sos, COORD_BITS'(x), COORD_BITS'(y), code};
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Load the pen if asked, then queue one word per lit cell and advance the pen
  function automatic void render_char(input in_item_t it);
    out_item_t cells [GLYPH_CELLS];
    int        glyph;
    int        n;
    glyph = -1;
    n = 0;
    if (it.start_of_string) begin
      pen_x = it.start_x;
      pen_y = it.start_y;
    end
    if (it.char_code == CHAR_SPACE) begin
      pen_x = pen_x + SPACE_ADVANCE;
    end else if (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE) begin
      glyph = int'(it.char_code - CHAR_ZERO);
    end else if (it.char_code == CHAR_SLASH) begin
      glyph = int'(SLASH_GLYPH);
    end
    if (glyph >= 0) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
          if (font[glyph][r][GLYPH_COLS-1-c]) begin
            cells[n].block_x     = pen_x + COORD_BITS'(CELL_SCALE * c);
            cells[n].block_y     = pen_y + COORD_BITS'(CELL_SCALE * r);
            cells[n].block_color = ink;
            cells[n].last_block  = 1'b0;
            n++;
          end
        end
      end
      cells[n-1].last_block = 1'b1;
      for (int k = 0; k < n; k++) pending_blocks.push_back(cells[k]);
      pen_x = pen_x + GLYPH_ADVANCE;
    end
  endfunction

  // Offer one character word and hold it until taken; typed rows override the prediction
  task automatic send_char(input in_item_t it, input bit typed, input int n_blocks,
                           input logic [COORD_BITS-1:0] fx, input logic [COORD_BITS-1:0] fy);
    int gap;
    int base;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    base = pending_blocks.size();
    render_char(it);
    if (typed) begin
      while (pending_blocks.size() > base + n_blocks) void'(pending_blocks.pop_back());
      if (n_blocks > 0) pending_blocks[base] = '{fx, fy, DRAW_COLOR_RESET, n_blocks == 1};
    end
  endtask

  // One string: usually a pen load on the first character, then mostly drawable content
  task automatic send_string(inout int drawn);
    in_item_t it;
    int       len;
    int       roll;
    bit       near_edge;
    len = $urandom_range(12, 1);
    near_edge = ($urandom_range(9) == 0);
    calm = ($urandom_range(4) == 0);
    for (int k = 0; k < len; k++) begin
      it.start_of_string = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(19) == 0);
      it.start_x = near_edge ? COORD_BITS'($urandom_range(4095, 4030)) : COORD_BITS'($urandom);
      it.start_y = near_edge ? COORD_BITS'($urandom_range(4095, 4070)) : COORD_BITS'($urandom);
      roll = $urandom_range(99);
      if (roll < 70) it.char_code = CHAR_ZERO + 8'($urandom_range(9));
      else if (roll < 80) it.char_code = CHAR_SLASH;
      else if (roll < 88) it.char_code = CHAR_SPACE;
      else it.char_code = 8'($urandom);
      if (it.char_code == CHAR_SPACE || it.char_code == CHAR_SLASH ||
          (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE)) drawn++;
      send_char(it, 1'b0, 0, '0, '0);
    end
  endtask

  task automatic write_color(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ink = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected word, then idle with no input to let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Receiver: random stall runs, plus one long hold to back the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held && words_seen >= 400 && in_valid) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_blocks
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (pending_blocks.size() == 0) begin
        $error("block word with nothing pending: x=%0d y=%0d", out_data.block_x,
               out_data.block_y);
        mismatches++;
      end else begin
        want = pending_blocks.pop_front();
        if (out_data.block_x !== want.block_x) begin
          $error("block_x: expected %0d, got %0d", want.block_x, out_data.block_x);
          mismatches++;
        end
        if (out_data.block_y !== want.block_y) begin
          $error("block_y: expected %0d, got %0d", want.block_y, out_data.block_y);
          mismatches++;
        end
        if (out_data.block_color !== want.block_color) begin
          $error("block_color: expected %h, got %h", want.block_color, out_data.block_color);
          mismatches++;
        end
        if (out_data.last_block !== want.last_block) begin
          $error("last_block: expected %b, got %b", want.last_block, out_data.last_block);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t tab [DIR_ROWS];
    int       drawn;
    tab = '{
      // after reset the pen sits at 0,0; start fields are ignored without the flag
      '{char_word(0, 4095, 4095, CHAR_SLASH), 1, 5, 6, 0},
      '{char_word(1, 0, 0, CHAR_ZERO), 1, 12, 0, 0},
      '{char_word(0, 4095, 0, CHAR_ZERO + 8'd1), 0, 0, 0, 0},
      '{char_word(0, 0, 4095, CHAR_ZERO + 8'd2), 0, 0, 0, 0},
      '{char_word(0, 1234, 567, CHAR_ZERO + 8'd3), 0, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd4), 0, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd5), 0, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd6), 0, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd7), 0, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd8), 0, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_NINE), 0, 0, 0, 0},
      // pen at the far corner: block corners and the advance wrap
      '{char_word(1, 4095, 4095, CHAR_ZERO + 8'd8), 1, 13, 4095, 4095},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd8), 0, 0, 0, 0},
      '{char_word(1, 4090, 4093, CHAR_SPACE), 1, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd7), 0, 0, 0, 0},
      // ignored byte still loads the pen
      '{char_word(1, 100, 200, 8'hFF), 1, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO + 8'd4), 0, 0, 0, 0},
      '{char_word(0, 0, 0, 8'h00), 1, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_SLASH - 8'd1), 1, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_NINE + 8'd1), 1, 0, 0, 0},
      '{char_word(0, 0, 0, CHAR_ZERO | 8'h80), 1, 0, 0, 0},
      '{char_word(1, 12'hAAA, 12'h555, CHAR_SLASH), 0, 0, 0, 0},
      '{char_word(1, 12'h555, 12'hAAA, CHAR_ZERO + 8'd8), 0, 0, 0, 0}
    };
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (tab[k])
      send_char(tab[k].item, tab[k].typed, tab[k].n_blocks, tab[k].first_x, tab[k].first_y);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) write_color(32'h0000_0000);
      else if (p == 1) write_color(32'hFFFF_FFFF);
      else write_color($urandom);
      drawn = 0;
      while (drawn < PHASE_CHARS) send_string(drawn);
    end
    drain();
    if (mismatches == 0 && pending_blocks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
